[src/fla_pkg.sv]
// ----------------------------------------------------------------------------
// Free list block allocator package
// Widths, limits, operation and status codes shared by the allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  // limits
  localparam int MAX_BLOCKS = 1024;
  localparam int MAX_RUN    = 64;

  // field widths
  localparam int OP_W      = 2;
  localparam int BYTES_W   = 24;
  localparam int BLK_W     = $clog2(MAX_BLOCKS);
  localparam int BCOUNT_W  = 11;
  localparam int BSIZE_W   = 17;
  localparam int ADDR_W    = 27;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_W   = $clog2(MAX_BLOCKS + 1);
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int QUOT_W    = BYTES_W + 1;
  localparam int REM_W     = BSIZE_W + 1;
  localparam int DIVCNT_W  = $clog2(QUOT_W);

  // stream and configuration widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = BSIZE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd1;

  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RESET = 17'd512;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOMEM     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

endpackage

[src/free_list_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Free list block allocator
// Fixed-size block allocator with a LIFO stack of freed blocks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transfer: tuser holds the operation
//   (init, allocate, free), tdata the byte request and the freed block.
//   m_axis returns one result per allocated block, or one status-only
//   result; tlast marks the final result of a command.
//   cfg writes block_count (index 0) and block_size (index 1); write them
//   only while no command is in flight. cfg_ready is always high.
// Sequence:
//   Init, free and unused codes: the command moves to S_REPLY, which loads the
//   result once the output register is free; the next command is then taken.
//   Allocate: bit-serial division of the rounded byte count by the block
//   size, a check step, then per block a stack memory read, an address
//   multiply and an output load. One command is in flight at a time.
// Reset:
//   The free stack is empty, no fresh blocks are left (init loads them),
//   block_count is 0 and block_size is 512. The stack memory is not cleared.
// Stalls:
//   Results sit in an output register; while the receiver holds tready low
//   the block finishes the current step and waits, and a new command is
//   taken once the previous command has loaded its final result.
// ----------------------------------------------------------------------------
module free_list_block_allocator_unit (
  input  logic                             clk,
  input  logic                             rst,
  // command stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [23:0] byte_request, [33:24] freed_block, [39:34] zero
  input  logic [fla_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] operation
  input  logic [fla_pkg::OP_W-1:0]         s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] block_number, [36:10] start_byte, [63:37] end_byte
  output logic [fla_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] status, [2] block_valid
  output logic [fla_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                             m_axis_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_REPLY,
    S_FETCH,
    S_MUL,
    S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [BCOUNT_W-1:0] block_count;
  logic [BSIZE_W-1:0]  block_size;
  logic [BSIZE_W-1:0]  bs_eff;

  // allocator state
  logic [DEPTH_W-1:0]  freed_depth;
  logic [DEPTH_W-1:0]  fresh_rem;

  // divider
  logic [QUOT_W-1:0]   quo;
  logic [REM_W-1:0]    rem;
  logic [DIVCNT_W-1:0] div_cnt;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    rem_diff;
  logic                rem_ge;

  // run bookkeeping
  logic [DEPTH_W:0]    avail;
  logic [RUN_W-1:0]    q_run;
  logic [RUN_W-1:0]    nfresh;
  logic [RUN_W-1:0]    nstack;
  logic [DEPTH_W-1:0]  depth_left;
  logic [DEPTH_W-1:0]  fresh_left_blk;
  logic [RUN_W-1:0]    run_left;
  logic [RUN_W-1:0]    fresh_left;
  logic [BLK_W-1:0]    fresh_ptr;
  logic [BLK_W-1:0]    stack_ptr;
  logic [BLK_W-1:0]    blk_sel;
  logic [BLK_W-1:0]    cur_blk;
  logic [ADDR_W-1:0]   prod;

  // held command
  logic [BYTES_W-1:0]  byte_request;
  logic [BLK_W-1:0]    freed_block;
  op_t                 op_in;
  logic                in_xfer;
  logic                push_en;

  // stack memory
  logic [BLK_W-1:0]    stack_mem [MAX_BLOCKS];
  logic [BLK_W-1:0]    rd_data;

  // result register
  status_t             reply_status;
  status_t             out_status;
  logic                out_blk_valid;
  logic [BLK_W-1:0]    out_blk;
  logic [ADDR_W-1:0]   out_start;
  logic [ADDR_W-1:0]   out_end;
  logic                out_free;
  logic                out_load;

  assign byte_request = s_axis_tdata[BYTES_W-1:0];
  assign freed_block  = s_axis_tdata[BYTES_W +: BLK_W];
  assign op_in        = op_t'(s_axis_tuser);

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && (state == S_REPLY || state == S_OUT);
  assign push_en       = in_xfer && (op_in == OP_FREE) &&
                         (freed_depth < DEPTH_W'(MAX_BLOCKS));

  assign m_axis_tdata = {out_end, out_start, out_blk};
  assign m_axis_tuser = {out_blk_valid, out_status};

  // treat a zero block size as one byte
  assign bs_eff = (block_size == '0) ? BSIZE_W'(1) : block_size;

  // one restoring division step
  assign rem_sh   = {rem[REM_W-2:0], quo[QUOT_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, bs_eff});
  assign rem_diff = rem_sh - {1'b0, bs_eff};

  // split the run between fresh blocks and the freed stack
  assign avail  = {1'b0, freed_depth} + {1'b0, fresh_rem};
  assign q_run  = quo[RUN_W-1:0];
  assign nfresh = ({{(DEPTH_W-RUN_W){1'b0}}, q_run} > freed_depth) ?
                  (q_run - freed_depth[RUN_W-1:0]) : '0;
  assign nstack = q_run - nfresh;
  assign depth_left     = freed_depth - {{(DEPTH_W-RUN_W){1'b0}}, nstack};
  assign fresh_left_blk = fresh_rem - {{(DEPTH_W-RUN_W){1'b0}}, nfresh};

  // fresh blocks go out first, then stack entries
  assign blk_sel = (fresh_left != '0) ? fresh_ptr : rd_data;

  // stack memory: write on free, registered read at the stack pointer
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[freed_depth[BLK_W-1:0]] <= freed_block;
    end
    rd_data <= stack_mem[stack_ptr];
  end

  // control, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      block_count   <= '0;
      block_size    <= BLOCK_SIZE_RESET;
      freed_depth   <= '0;
      fresh_rem     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BLOCK_COUNT) begin
          block_count <= cfg_data[BCOUNT_W-1:0];
        end else begin
          block_size <= cfg_data;
        end
      end

      // drop a result once transferred, unless the next one is loaded
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (op_in)
              OP_INIT: begin
                freed_depth  <= '0;
                fresh_rem    <= (block_count > BCOUNT_W'(MAX_BLOCKS)) ?
                                DEPTH_W'(MAX_BLOCKS) : DEPTH_W'(block_count);
                reply_status <= ST_OK;
                state        <= S_REPLY;
              end
              OP_FREE: begin
                if (push_en) begin
                  freed_depth  <= freed_depth + DEPTH_W'(1);
                  reply_status <= ST_OK;
                end else begin
                  reply_status <= ST_OVERFLOW;
                end
                state <= S_REPLY;
              end
              OP_ALLOC: begin
                quo     <= QUOT_W'(byte_request) + QUOT_W'(bs_eff) - QUOT_W'(1);
                rem     <= '0;
                div_cnt <= DIVCNT_W'(QUOT_W - 1);
                state   <= S_DIV;
              end
              default: begin
                reply_status <= ST_OK;
                state        <= S_REPLY;
              end
            endcase
          end
        end

        S_DIV: begin
          quo <= {quo[QUOT_W-2:0], rem_ge};
          rem <= rem_ge ? rem_diff : rem_sh;
          if (div_cnt == '0) begin
            state <= S_CHECK;
          end else begin
            div_cnt <= div_cnt - DIVCNT_W'(1);
          end
        end

        S_CHECK: begin
          priority if (avail == '0) begin
            reply_status <= ST_NOMEM;
            state        <= S_REPLY;
          end else if (quo > QUOT_W'(MAX_RUN)) begin
            reply_status <= ST_TOO_LARGE;
            state        <= S_REPLY;
          end else if (quo > QUOT_W'(avail)) begin
            reply_status <= ST_NOMEM;
            state        <= S_REPLY;
          end else if (quo == '0) begin
            reply_status <= ST_OK;
            state        <= S_REPLY;
          end else begin
            // take the whole run now and emit it block by block
            freed_depth <= depth_left;
            fresh_rem   <= fresh_left_blk;
            fresh_ptr   <= fresh_left_blk[BLK_W-1:0];
            stack_ptr   <= depth_left[BLK_W-1:0];
            run_left    <= q_run;
            fresh_left  <= nfresh;
            state       <= S_FETCH;
          end
        end

        S_REPLY: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= 1'b1;
            out_status    <= reply_status;
            out_blk_valid <= 1'b0;
            out_blk       <= '0;
            out_start     <= '0;
            out_end       <= '0;
            state         <= S_IDLE;
          end
        end

        S_FETCH: begin
          state <= S_MUL;
        end

        S_MUL: begin
          cur_blk <= blk_sel;
          prod    <= ADDR_W'(blk_sel * bs_eff);
          state   <= S_OUT;
        end

        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= (run_left == RUN_W'(1));
            out_status    <= ST_OK;
            out_blk_valid <= 1'b1;
            out_blk       <= cur_blk;
            out_start     <= prod + ADDR_W'(1);
            out_end       <= prod + ADDR_W'(bs_eff);
            run_left      <= run_left - RUN_W'(1);
            if (fresh_left != '0) begin
              fresh_left <= fresh_left - RUN_W'(1);
              fresh_ptr  <= fresh_ptr + BLK_W'(1);
            end else begin
              stack_ptr <= stack_ptr + BLK_W'(1);
            end
            state <= (run_left == RUN_W'(1)) ? S_IDLE : S_FETCH;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    freed_depth <= DEPTH_W'(MAX_BLOCKS))
    else $error("freed stack depth beyond capacity");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_MUL || state == S_OUT) |-> (run_left != '0))
    else $error("emitting with an empty run");

  a_fresh_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_MUL || state == S_OUT) |-> (fresh_left <= run_left))
    else $error("fresh count exceeds remaining run");

  a_block_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_blk_valid) |-> (out_status == ST_OK))
    else $error("block result with an error status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("command accepted while the previous one is in flight");

endmodule
